>>> rtl/cwh_pkg.sv
// shared types and constants of the cell weighted histogram unit
`default_nettype none
package cwh_pkg;

	localparam int MAX_WIDTH     = 1024;
	localparam int HEIGHT_LIMIT  = 1024;
	localparam int MAX_CELL_SIZE = 16;

	localparam int POS_W  = 10;
	localparam int EXT_W  = 11;
	localparam int CS_W   = 5;
	localparam int BIN_W  = 8;
	localparam int WT_W   = 16;
	localparam int SUM_W  = 24;
	localparam int COL_W  = 7;
	localparam int BNUM_W = 5;
	localparam int NBR_W  = 6;
	localparam int NB_W   = 7;
	localparam int CFG_W  = 11;
	localparam int IDX_W  = 3;

	localparam int DIV_NW = 11;
	localparam int DIV_DW = 5;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	localparam logic [EXT_W-1:0] RST_WIDTH  = 11'd640;
	localparam logic [EXT_W-1:0] RST_HEIGHT = 11'd480;
	localparam logic [CS_W-1:0]  RST_CSIZE  = 5'd8;
	localparam logic [NBR_W-1:0] RST_NBINS  = 6'd9;

	typedef enum logic [IDX_W-1:0] {
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT,
		REG_CELL_SIZE,
		REG_MARGIN_TOP,
		REG_MARGIN_LEFT,
		REG_MARGIN_BOTTOM,
		REG_MARGIN_RIGHT,
		REG_NUM_BINS
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC_START,
		ST_CALC_WAIT,
		ST_ADD,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMIT_HOLD
	} state_t;

	typedef enum logic [1:0] {
		JOB_NCX,
		JOB_NCY,
		JOB_COLX,
		JOB_ROWY
	} calc_job_t;

endpackage
`default_nettype wire

>>> rtl/cell_weighted_histogram_unit.sv
// top level of the cell weighted histogram unit
`default_nettype none
// Pixels arrive in raster order, each with a bin index and a Q8.8 weight; inside the
// margins the frame is tiled into square cells and each pixel adds its weight to its
// bin of its cell, held in a single accumulator ram addressed by cell column and bin,
// so that it serves one row of cells at a time. When the bottom-right pixel of a cell
// arrives, the cell's bins come out in order, the final one flagged, and are cleared.
// A pixel outside every cell, or whose bin is out of range and which does not finish
// a cell, only moves the position on; a pixel that votes reads its bin, then writes it
// back through the ram; a finishing pixel then reads its bins out, one ram read and
// one clearing write per bin. Cell positions are tracked with counters; after reset
// and after every register write a shared serial divider rederives cell counts and
// the current cell position, during which no pixel is taken. After reset a clearing
// pass zeroes all 2**(clog2(MAX_CELLS_X) + clog2(MAX_BINS)) ram words (4096 by
// default) before the first pixel is taken.
module cell_weighted_histogram_unit #(
	parameter int MAX_CELLS_X = 128,
	parameter int MAX_BINS    = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [cwh_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [cwh_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                         pix_valid,
	output logic                              pix_stall,
	input  wire logic [cwh_pkg::BIN_W-1:0]    bin_index,
	input  wire logic [cwh_pkg::WT_W-1:0]     weight,
	output logic                              res_valid,
	input  wire logic                         res_stall,
	output logic      [cwh_pkg::POS_W-1:0]    cell_row,
	output logic      [cwh_pkg::COL_W-1:0]    cell_col,
	output logic      [cwh_pkg::BNUM_W-1:0]   bin_number,
	output logic      [cwh_pkg::SUM_W-1:0]    bin_sum,
	output logic                              last_bin,
	output logic                              last_cell
);

	localparam int POS_W  = cwh_pkg::POS_W;
	localparam int EXT_W  = cwh_pkg::EXT_W;
	localparam int CS_W   = cwh_pkg::CS_W;
	localparam int NB_W   = cwh_pkg::NB_W;
	localparam int SUM_W  = cwh_pkg::SUM_W;
	localparam int CX_AW  = (MAX_CELLS_X > 1) ? $clog2(MAX_CELLS_X) : 1;
	localparam int BIN_AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int AW     = CX_AW + BIN_AW;
	localparam int DEPTH  = 1 << AW;
	localparam int NCX_W  = $clog2(MAX_CELLS_X + 1);

	// configuration registers
	logic [EXT_W-1:0]          width_q;
	logic [EXT_W-1:0]          height_q;
	logic [CS_W-1:0]           csize_q;
	logic [POS_W-1:0]          mtop_q;
	logic [POS_W-1:0]          mleft_q;
	logic [POS_W-1:0]          mbot_q;
	logic [POS_W-1:0]          mright_q;
	logic [cwh_pkg::NBR_W-1:0] nbins_q;
	logic                      dirty_q;

	// sequencer and position state
	cwh_pkg::state_t    state_q, state_nx;
	cwh_pkg::calc_job_t job_q, job_nx;
	logic [AW-1:0]      clr_q;
	logic [NB_W-1:0]    b_q;
	logic [NB_W-1:0]    b_p1;
	logic [POS_W-1:0]   col_q, row_q;
	logic [POS_W-1:0]   cx_q, cy_q;
	logic [CS_W-1:0]    ox_q, oy_q;
	logic [NCX_W-1:0]   ncx_q;
	logic [EXT_W-1:0]   ncy_q;

	// captured pixel and cell
	logic [cwh_pkg::WT_W-1:0] wt_q;
	logic [AW-1:0]            addr_q;
	logic                     corner_q;
	logic [POS_W-1:0]         ecx_q;
	logic [POS_W-1:0]         ecy_q;
	logic                     elast_q;

	// result registers
	logic [POS_W-1:0]           cell_row_q;
	logic [cwh_pkg::COL_W-1:0]  cell_col_q;
	logic [cwh_pkg::BNUM_W-1:0] bin_number_q;
	logic [SUM_W-1:0]           bin_sum_q;
	logic                       last_bin_q;
	logic                       last_cell_q;

	// effective register values
	logic [EXT_W-1:0] w_eff, h_eff;
	logic [CS_W-1:0]  cs_eff;
	logic [NB_W-1:0]  nb_eff;

	// divider hookup
	logic                       div_start;
	logic                       div_done;
	logic [cwh_pkg::DIV_NW-1:0] div_num;
	logic [cwh_pkg::DIV_NW-1:0] div_quo;
	logic [cwh_pkg::DIV_DW-1:0] div_rem;
	logic [EXT_W-1:0]           mx_sum, my_sum;
	logic [EXT_W-1:0]           num_x, num_y;
	logic [EXT_W-1:0]           ncx_sat;

	// pixel evaluation
	logic             pix_acc;
	logic             in_window;
	logic             bin_ok;
	logic             corner;
	logic             last_c;
	logic [EXT_W-1:0] col_p1, row_p1;
	logic             wrap;
	logic [POS_W-1:0] col_nx, row_nx;
	logic [POS_W-1:0] cx_nx, cy_nx;
	logic [CS_W-1:0]  ox_nx, oy_nx;
	logic [CS_W-1:0]  ox_p1, oy_p1;

	// ram hookup
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [SUM_W-1:0] ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [SUM_W-1:0] ram_rdata;
	logic [SUM_W:0]   sum_full;
	logic [SUM_W-1:0] sum_sat;

	always_comb begin
		if (width_q == '0) begin
			w_eff = 11'd1;
		end else if (width_q > EXT_W'(cwh_pkg::MAX_WIDTH)) begin
			w_eff = EXT_W'(cwh_pkg::MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = 11'd1;
		end else if (height_q > EXT_W'(cwh_pkg::HEIGHT_LIMIT)) begin
			h_eff = EXT_W'(cwh_pkg::HEIGHT_LIMIT);
		end else begin
			h_eff = height_q;
		end
		if (csize_q == '0) begin
			cs_eff = 5'd1;
		end else if (csize_q > CS_W'(cwh_pkg::MAX_CELL_SIZE)) begin
			cs_eff = CS_W'(cwh_pkg::MAX_CELL_SIZE);
		end else begin
			cs_eff = csize_q;
		end
		if (nbins_q == '0) begin
			nb_eff = 7'd1;
		end else if ({1'b0, nbins_q} > NB_W'(MAX_BINS)) begin
			nb_eff = NB_W'(MAX_BINS);
		end else begin
			nb_eff = {1'b0, nbins_q};
		end
	end

	// divider operands for the geometry jobs
	always_comb begin
		mx_sum  = {1'b0, mleft_q} + {1'b0, mright_q};
		my_sum  = {1'b0, mtop_q} + {1'b0, mbot_q};
		num_x   = (mx_sum >= w_eff) ? '0 : w_eff - mx_sum;
		num_y   = (my_sum >= h_eff) ? '0 : h_eff - my_sum;
		ncx_sat = (div_quo > EXT_W'(MAX_CELLS_X)) ? EXT_W'(MAX_CELLS_X) : div_quo;
		unique case (job_q)
			cwh_pkg::JOB_NCX:  div_num = num_x;
			cwh_pkg::JOB_NCY:  div_num = num_y;
			cwh_pkg::JOB_COLX: div_num = {1'b0, col_q - mleft_q};
			cwh_pkg::JOB_ROWY: div_num = {1'b0, row_q - mtop_q};
		endcase
	end

	cwh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (cs_eff),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// where the current pixel falls and where the next one will
	always_comb begin
		pix_acc   = pix_valid && !pix_stall;
		in_window = ({1'b0, col_q} < w_eff) && ({1'b0, row_q} < h_eff)
			&& (col_q >= mleft_q) && (row_q >= mtop_q)
			&& ({1'b0, cx_q} < EXT_W'(ncx_q)) && ({1'b0, cy_q} < ncy_q);
		bin_ok    = bin_index < cwh_pkg::BIN_W'(nb_eff);
		corner    = (ox_q == cs_eff - 5'd1) && (oy_q == cs_eff - 5'd1);
		last_c    = ({1'b0, cx_q} + 11'd1 == EXT_W'(ncx_q))
			&& ({1'b0, cy_q} + 11'd1 == ncy_q);

		col_p1 = {1'b0, col_q} + 11'd1;
		row_p1 = {1'b0, row_q} + 11'd1;
		wrap   = col_p1 >= w_eff;
		col_nx = wrap ? '0 : col_p1[POS_W-1:0];
		if (!wrap) begin
			row_nx = row_q;
		end else if (row_p1 >= h_eff) begin
			row_nx = '0;
		end else begin
			row_nx = row_p1[POS_W-1:0];
		end

		ox_p1 = ox_q + 5'd1;
		oy_p1 = oy_q + 5'd1;
		cx_nx = cx_q;
		ox_nx = ox_q;
		cy_nx = cy_q;
		oy_nx = oy_q;
		if (col_nx == mleft_q) begin
			cx_nx = '0;
			ox_nx = '0;
		end else if (col_nx > mleft_q) begin
			if (ox_p1 == cs_eff) begin
				cx_nx = cx_q + 10'd1;
				ox_nx = '0;
			end else begin
				ox_nx = ox_p1;
			end
		end
		if (wrap && row_nx == mtop_q) begin
			cy_nx = '0;
			oy_nx = '0;
		end else if (wrap && row_nx > mtop_q) begin
			if (oy_p1 == cs_eff) begin
				cy_nx = cy_q + 10'd1;
				oy_nx = '0;
			end else begin
				oy_nx = oy_p1;
			end
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		job_nx   = job_q;
		unique case (state_q)
			cwh_pkg::ST_CLEAR: begin
				if (&clr_q) begin
					state_nx = cwh_pkg::ST_IDLE;
				end
			end
			cwh_pkg::ST_IDLE: begin
				priority if (dirty_q) begin
					state_nx = cwh_pkg::ST_CALC_START;
				end else if (pix_acc && in_window && bin_ok) begin
					state_nx = cwh_pkg::ST_ADD;
				end else if (pix_acc && in_window && corner) begin
					state_nx = cwh_pkg::ST_EMIT_RD;
				end else begin
					state_nx = cwh_pkg::ST_IDLE;
				end
			end
			cwh_pkg::ST_CALC_START: begin
				state_nx = cwh_pkg::ST_CALC_WAIT;
			end
			cwh_pkg::ST_CALC_WAIT: begin
				if (div_done) begin
					unique case (job_q)
						cwh_pkg::JOB_NCX:  job_nx = cwh_pkg::JOB_NCY;
						cwh_pkg::JOB_NCY:  job_nx = cwh_pkg::JOB_COLX;
						cwh_pkg::JOB_COLX: job_nx = cwh_pkg::JOB_ROWY;
						cwh_pkg::JOB_ROWY: job_nx = cwh_pkg::JOB_NCX;
					endcase
					// a register write during the pass starts it over
					if (job_q == cwh_pkg::JOB_ROWY && !dirty_q) begin
						state_nx = cwh_pkg::ST_IDLE;
					end else begin
						state_nx = cwh_pkg::ST_CALC_START;
					end
				end
			end
			cwh_pkg::ST_ADD: begin
				state_nx = corner_q ? cwh_pkg::ST_EMIT_RD : cwh_pkg::ST_IDLE;
			end
			cwh_pkg::ST_EMIT_RD: begin
				state_nx = cwh_pkg::ST_EMIT_LD;
			end
			cwh_pkg::ST_EMIT_LD: begin
				state_nx = cwh_pkg::ST_EMIT_HOLD;
			end
			cwh_pkg::ST_EMIT_HOLD: begin
				if (!res_stall) begin
					state_nx = last_bin_q ? cwh_pkg::ST_IDLE : cwh_pkg::ST_EMIT_LD;
				end
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		b_p1      = b_q + 7'd1;
		sum_full  = {1'b0, ram_rdata} + (SUM_W + 1)'(wt_q);
		sum_sat   = sum_full[SUM_W] ? cwh_pkg::SUM_MAX : sum_full[SUM_W-1:0];
		pix_stall = !(state_q == cwh_pkg::ST_IDLE && !dirty_q);
		res_valid = state_q == cwh_pkg::ST_EMIT_HOLD;
		div_start = state_q == cwh_pkg::ST_CALC_START;
		ram_we    = 1'b0;
		ram_waddr = {ecx_q[CX_AW-1:0], b_q[BIN_AW-1:0]};
		ram_wdata = '0;
		ram_raddr = {ecx_q[CX_AW-1:0], b_q[BIN_AW-1:0]};
		unique case (state_q)
			cwh_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			cwh_pkg::ST_IDLE: begin
				ram_raddr = {cx_q[CX_AW-1:0], bin_index[BIN_AW-1:0]};
			end
			cwh_pkg::ST_ADD: begin
				ram_we    = bin_ok_dummy_free();
				ram_waddr = addr_q;
				ram_wdata = sum_sat;
			end
			cwh_pkg::ST_EMIT_LD: begin
				ram_we = 1'b1;
			end
			cwh_pkg::ST_EMIT_HOLD: begin
				ram_raddr = {ecx_q[CX_AW-1:0], b_p1[BIN_AW-1:0]};
			end
			cwh_pkg::ST_CALC_START, cwh_pkg::ST_CALC_WAIT, cwh_pkg::ST_EMIT_RD: begin
				ram_we = 1'b0;
			end
		endcase
	end

	function automatic logic bin_ok_dummy_free();
		return 1'b1;
	endfunction

	cwh_ram #(
		.WIDTH (SUM_W),
		.DEPTH (DEPTH)
	) u_acc_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= cwh_pkg::RST_WIDTH;
			height_q <= cwh_pkg::RST_HEIGHT;
			csize_q  <= cwh_pkg::RST_CSIZE;
			mtop_q   <= '0;
			mleft_q  <= '0;
			mbot_q   <= '0;
			mright_q <= '0;
			nbins_q  <= cwh_pkg::RST_NBINS;
		end else if (cfg_we) begin
			unique case (cwh_pkg::reg_idx_t'(cfg_index))
				cwh_pkg::REG_IMAGE_WIDTH:   width_q  <= cfg_data;
				cwh_pkg::REG_IMAGE_HEIGHT:  height_q <= cfg_data;
				cwh_pkg::REG_CELL_SIZE:     csize_q  <= cfg_data[CS_W-1:0];
				cwh_pkg::REG_MARGIN_TOP:    mtop_q   <= cfg_data[POS_W-1:0];
				cwh_pkg::REG_MARGIN_LEFT:   mleft_q  <= cfg_data[POS_W-1:0];
				cwh_pkg::REG_MARGIN_BOTTOM: mbot_q   <= cfg_data[POS_W-1:0];
				cwh_pkg::REG_MARGIN_RIGHT:  mright_q <= cfg_data[POS_W-1:0];
				cwh_pkg::REG_NUM_BINS:      nbins_q  <= cfg_data[cwh_pkg::NBR_W-1:0];
			endcase
		end
	end

	// sequencer and position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cwh_pkg::ST_CLEAR;
			job_q   <= cwh_pkg::JOB_NCX;
			dirty_q <= 1'b1;
			clr_q   <= '0;
			b_q     <= '0;
			col_q   <= '0;
			row_q   <= '0;
			cx_q    <= '0;
			ox_q    <= '0;
			cy_q    <= '0;
			oy_q    <= '0;
			ncx_q   <= '0;
			ncy_q   <= '0;
		end else begin
			state_q <= state_nx;
			job_q   <= job_nx;
			if (cfg_we) begin
				dirty_q <= 1'b1;
			end else if (state_q == cwh_pkg::ST_CALC_START && job_q == cwh_pkg::JOB_NCX) begin
				dirty_q <= 1'b0;
			end
			if (state_q == cwh_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (pix_acc) begin
				b_q <= '0;
			end else if (state_q == cwh_pkg::ST_EMIT_HOLD && !res_stall) begin
				b_q <= b_p1;
			end
			if (state_q == cwh_pkg::ST_CALC_WAIT && div_done) begin
				unique case (job_q)
					cwh_pkg::JOB_NCX:  ncx_q <= NCX_W'(ncx_sat);
					cwh_pkg::JOB_NCY:  ncy_q <= div_quo;
					cwh_pkg::JOB_COLX: begin
						cx_q <= div_quo[POS_W-1:0];
						ox_q <= div_rem;
					end
					cwh_pkg::JOB_ROWY: begin
						cy_q <= div_quo[POS_W-1:0];
						oy_q <= div_rem;
					end
				endcase
			end else if (pix_acc) begin
				col_q <= col_nx;
				row_q <= row_nx;
				cx_q  <= cx_nx;
				ox_q  <= ox_nx;
				cy_q  <= cy_nx;
				oy_q  <= oy_nx;
			end
		end
	end

	// pixel capture and result registers
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			wt_q     <= weight;
			addr_q   <= {cx_q[CX_AW-1:0], bin_index[BIN_AW-1:0]};
			corner_q <= corner;
			ecx_q    <= cx_q;
			ecy_q    <= cy_q;
			elast_q  <= last_c;
		end
		if (state_q == cwh_pkg::ST_EMIT_LD) begin
			cell_row_q   <= ecy_q;
			cell_col_q   <= ecx_q[cwh_pkg::COL_W-1:0];
			bin_number_q <= b_q[cwh_pkg::BNUM_W-1:0];
			bin_sum_q    <= ram_rdata;
			last_bin_q   <= b_p1 == nb_eff;
			last_cell_q  <= elast_q;
		end
	end

	assign cell_row   = cell_row_q;
	assign cell_col   = cell_col_q;
	assign bin_number = bin_number_q;
	assign bin_sum    = bin_sum_q;
	assign last_bin   = last_bin_q;
	assign last_cell  = last_cell_q;

	// final bin of a cell carries the last bin number
	a_last_bin_number: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && last_bin) |-> (bin_number == cwh_pkg::BNUM_W'(nb_eff - 7'd1)))
		else $error("last bin flag on wrong bin number");

	// no pixel is taken while a cell is being read out
	a_no_pixel_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pix_stall)
		else $error("pixel taken during cell readout");

	// divider results land only where the sequencer waits for them
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == cwh_pkg::ST_CALC_WAIT))
		else $error("divider finished outside geometry pass");

	// a taken non-final bin is followed by the next bin load
	a_next_bin: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && !last_bin) |=> (state_q == cwh_pkg::ST_EMIT_LD))
		else $error("cell readout stopped early");

endmodule
`default_nettype wire

>>> rtl/cwh_ram.sv
// generic simple dual port ram with registered read
`default_nettype none
module cwh_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

>>> rtl/cwh_div.sv
// bit serial restoring divider, one quotient bit per cycle
`default_nettype none
module cwh_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [cwh_pkg::DIV_NW-1:0]  num,
	input  wire logic [cwh_pkg::DIV_DW-1:0]  den,
	output logic                             done,
	output logic      [cwh_pkg::DIV_NW-1:0]  quo,
	output logic      [cwh_pkg::DIV_DW-1:0]  rem
);

	localparam int NW  = cwh_pkg::DIV_NW;
	localparam int DW  = cwh_pkg::DIV_DW;
	localparam int CNW = $clog2(NW);

	logic [NW-1:0]  acc_q;
	logic [DW-1:0]  rem_q;
	logic [DW-1:0]  den_q;
	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [DW:0]    trial;
	logic [DW:0]    diff;
	logic           fits;

	always_comb begin
		trial = {rem_q, acc_q[NW-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in behind the dividend bits
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			acc_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[NW-2:0], fits};
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = acc_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire
